// File: rtl/aeps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aeps_pkg
// Shared types and constants for the active/expired priority scheduler.
// ----------------------------------------------------------------------------
package aeps_pkg;

    localparam int NUM_PROCS      = 64;
    localparam int NUM_PRIORITIES = 16;
    localparam int PROC_W         = 6;
    localparam int PRIO_W         = 4;
    localparam int NUM_FIFOS      = 2 * NUM_PRIORITIES;
    localparam int FIFO_W         = 5;
    localparam int FCNT_W         = 7;
    localparam int CYC_W          = 32;
    localparam int DIV_W          = PRIO_W + 1;
    localparam int SLOT_AW        = FIFO_W + PROC_W;
    localparam int BITS_PER_STEP  = 4;
    localparam int DIV_STEPS      = CYC_W / BITS_PER_STEP;
    localparam int STEP_W         = 3;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_REINSERT = 2'd1;
    localparam logic [1:0] OP_PICK     = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [PROC_W-1:0] proc_id;
        logic [PRIO_W-1:0] priority_req;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [PROC_W-1:0] picked_proc;
        logic              went_active;
    } t_out;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic push;
        logic pop;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
    } t_sts;

endpackage
`default_nettype wire

// File: rtl/aeps_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aeps_dp
// Datapath: cycle counters, fifo storage, head/count tables, remainder unit.
// ----------------------------------------------------------------------------
module aeps_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  aeps_pkg::t_cmd     i_cmd,
    output aeps_pkg::t_sts     o_sts,
    input  aeps_pkg::t_in      i_in_data,
    output aeps_pkg::t_out     o_out_data
);
    import aeps_pkg::*;

    logic [CYC_W-1:0]   r_cmem [NUM_PROCS];
    logic [NUM_PROCS-1:0] r_cvalid;
    logic [PROC_W-1:0]  r_smem [2**SLOT_AW];
    logic [PROC_W-1:0]  r_head [NUM_FIFOS];
    logic [FCNT_W-1:0]  r_fcnt [NUM_FIFOS];
    logic [NUM_FIFOS-1:0] r_ne;
    logic               r_bank;

    t_in                r_item;
    logic [CYC_W-1:0]   r_cq;
    logic [CYC_W-1:0]   r_dvd;
    logic [DIV_W-1:0]   r_rem;
    logic [PROC_W-1:0]  r_slot_q;
    logic [1:0]         r_status;
    logic               r_active;
    logic               r_found;
    t_out               r_out;

    logic [CYC_W-1:0]   w_cnow;
    logic [DIV_W-1:0]   w_div;
    logic [DIV_W-1:0]   n_rem;
    logic [CYC_W-1:0]   n_dvd;
    logic               w_to_active;
    logic [FIFO_W-1:0]  w_push_f;
    logic               w_full;
    logic [PROC_W-1:0]  w_pos;
    logic [NUM_PRIORITIES-1:0] w_ne_a;
    logic [NUM_PRIORITIES-1:0] w_ne_b;
    logic               w_pop_found;
    logic               w_pop_swap;
    logic [PRIO_W-1:0]  w_pop_p;
    logic [FIFO_W-1:0]  w_pop_f;

    assign o_sts.op   = r_item.opcode;
    assign o_out_data = r_out;

    // unwritten counters read as zero
    assign w_cnow = r_cvalid[r_item.proc_id] ? r_cq : '0;
    assign w_div  = {1'b0, r_item.priority_req} + DIV_W'(1);

    // restoring remainder, BITS_PER_STEP bits per divide step
    always_comb begin
        logic [DIV_W:0] t;
        n_rem = r_rem;
        n_dvd = r_dvd;
        t     = '0;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            t = {n_rem, n_dvd[CYC_W-1]};
            if (t >= {1'b0, w_div}) begin
                t = t - {1'b0, w_div};
            end
            n_rem = t[DIV_W-1:0];
            n_dvd = {n_dvd[CYC_W-2:0], 1'b0};
        end
    end

    assign w_to_active = (r_item.opcode == OP_INSERT) || (r_rem == '0);
    assign w_push_f    = {w_to_active ? r_bank : ~r_bank, r_item.priority_req};
    assign w_full      = (r_fcnt[w_push_f] == FCNT_W'(NUM_PROCS));
    assign w_pos       = r_head[w_push_f] + r_fcnt[w_push_f][PROC_W-1:0];

    // first non-empty priority, active bank first
    always_comb begin
        w_ne_a      = r_bank ? r_ne[NUM_FIFOS-1:NUM_PRIORITIES] : r_ne[NUM_PRIORITIES-1:0];
        w_ne_b      = r_bank ? r_ne[NUM_PRIORITIES-1:0] : r_ne[NUM_FIFOS-1:NUM_PRIORITIES];
        w_pop_found = 1'b1;
        w_pop_swap  = 1'b0;
        w_pop_p     = '0;
        priority if (w_ne_a != '0) begin
            for (int p = NUM_PRIORITIES - 1; p >= 0; p--) begin
                if (w_ne_a[p]) w_pop_p = PRIO_W'(p);
            end
        end else if (w_ne_b != '0) begin
            w_pop_swap = 1'b1;
            for (int p = NUM_PRIORITIES - 1; p >= 0; p--) begin
                if (w_ne_b[p]) w_pop_p = PRIO_W'(p);
            end
        end else begin
            w_pop_found = 1'b0;
        end
        w_pop_f = {r_bank ^ w_pop_swap, w_pop_p};
    end

    // memories
    always_ff @(posedge i_clk) begin
        r_cq <= r_cmem[r_item.proc_id];
        if (i_cmd.div_init) begin
            r_cmem[r_item.proc_id] <= (r_item.opcode == OP_INSERT) ? '0 : w_cnow + CYC_W'(1);
        end
        if (i_cmd.push && !w_full) begin
            r_smem[{w_push_f, w_pos}] <= r_item.proc_id;
        end
        if (i_cmd.pop) begin
            r_slot_q <= r_smem[{w_pop_f, r_head[w_pop_f]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
            r_ne     <= '0;
            r_bank   <= 1'b0;
            for (int f = 0; f < NUM_FIFOS; f++) begin
                r_head[f] <= '0;
                r_fcnt[f] <= '0;
            end
        end else begin
            if (i_cmd.div_init) begin
                r_cvalid[r_item.proc_id] <= 1'b1;
            end
            if (i_cmd.push && !w_full) begin
                r_fcnt[w_push_f] <= r_fcnt[w_push_f] + FCNT_W'(1);
                r_ne[w_push_f]   <= 1'b1;
            end
            if (i_cmd.pop && w_pop_found) begin
                r_head[w_pop_f] <= r_head[w_pop_f] + PROC_W'(1);
                r_fcnt[w_pop_f] <= r_fcnt[w_pop_f] - FCNT_W'(1);
                r_ne[w_pop_f]   <= (r_fcnt[w_pop_f] != FCNT_W'(1));
                r_bank          <= r_bank ^ w_pop_swap;
            end
        end
    end

    // item and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item   <= i_in_data;
            r_status <= ST_OK;
            r_active <= 1'b0;
            r_found  <= 1'b0;
        end
        if (i_cmd.div_init) begin
            r_dvd <= w_cnow;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
        if (i_cmd.push) begin
            r_status <= w_full ? ST_FULL : ST_OK;
            r_active <= w_to_active && !w_full;
        end
        if (i_cmd.pop) begin
            r_status <= w_pop_found ? ST_OK : ST_NONE;
            r_found  <= w_pop_found;
        end
        if (i_cmd.emit) begin
            r_out.status      <= r_status;
            r_out.picked_proc <= r_found ? r_slot_q : '0;
            r_out.went_active <= r_active;
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push && !w_full |-> r_fcnt[w_push_f] < FCNT_W'(NUM_PROCS))
        else $error("fifo count overflow");
    a_ne_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop && w_pop_found |-> r_fcnt[w_pop_f] != '0)
        else $error("pop from empty fifo");
    a_pop_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop && !w_pop_found |=> $stable(r_bank))
        else $error("bank swapped on empty pick");

endmodule
`default_nettype wire

// File: rtl/aeps_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aeps_ctrl
// Sequencer for one item and the output valid register.
// ----------------------------------------------------------------------------
module aeps_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output aeps_pkg::t_cmd     o_cmd,
    input  aeps_pkg::t_sts     i_sts
);
    import aeps_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_DINIT = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_PUSH  = 3'd4;
    localparam logic [2:0] S_POP   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              w_in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                priority if (i_sts.op == OP_PICK) begin
                    n_state = S_POP;
                end else if (i_sts.op == OP_INSERT || i_sts.op == OP_REINSERT) begin
                    n_state = S_DINIT;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = (i_sts.op == OP_INSERT) ? S_PUSH : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_EMIT;
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_RD)
        else $error("item accepted but sequencer idle");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !r_out_valid || i_out_ready)
        else $error("result overwritten");
    a_step_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != '0 |-> r_state == S_DIV || r_state == S_PUSH)
        else $error("step counter outside divide");

endmodule
`default_nettype wire

// File: rtl/active_expired_priority_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// active_expired_priority_scheduler
// Two-bank priority scheduler with per-priority fifos and counter policy.
// ----------------------------------------------------------------------------
// sequence: pick runs read, pop, emit; new insert runs read, divide init,
//   push, emit; reinsert adds divide steps of 4 bits each before push;
//   unused opcode runs read, emit; one item at a time, taken while idle;
//   output register lets the next item start while a result waits
// reset: synchronous active low; clears counters' valid bits, fifo heads and
//   counts, bank select; fifo storage is not cleared
module active_expired_priority_scheduler (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  aeps_pkg::t_in      i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output aeps_pkg::t_out     o_out_data
);
    import aeps_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    aeps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    aeps_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule
`default_nettype wire
